// ===== hw/rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared widths and constants for the strongly connected components block.
// ----------------------------------------------------------------------------
package scc_pkg;
    localparam int MAX_NODES_DEF = 64;
    localparam int MAX_EDGES_DEF = 256;
    localparam int NODE_W        = 7;
    localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;
endpackage

// ===== hw/rtl/scc_edge_mem.sv =====
// ----------------------------------------------------------------------------
// scc_edge_mem
// Edge store: source and target node per edge, one write and one read port,
// read data registered.
// ----------------------------------------------------------------------------
module scc_edge_mem #(
    parameter int MAX_EDGES = 256,
    parameter int AW        = 8
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [scc_pkg::NODE_W-1:0] i_wsrc,
    input  logic [scc_pkg::NODE_W-1:0] i_wdst,
    input  logic [AW-1:0]             i_raddr,
    output logic [scc_pkg::NODE_W-1:0] o_rsrc,
    output logic [scc_pkg::NODE_W-1:0] o_rdst
);
    import scc_pkg::*;
    logic [2*NODE_W-1:0] mem [MAX_EDGES];
    logic [2*NODE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wsrc, i_wdst};
        end
        r_q <= mem[i_raddr];
    end

    assign o_rsrc = r_q[2*NODE_W-1:NODE_W];
    assign o_rdst = r_q[NODE_W-1:0];
endmodule

// ===== hw/rtl/scc_node_mem.sv =====
// ----------------------------------------------------------------------------
// scc_node_mem
// Node-indexed store (stack frames, orders, members), one write and one read
// port, read data registered.
// ----------------------------------------------------------------------------
module scc_node_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_q <= mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// ===== hw/rtl/strongly_connected_components.sv =====
// ----------------------------------------------------------------------------
// strongly_connected_components
// Loads directed edges, then finds strongly connected components by two
// stack-based depth-first passes and streams one result per node.
// ----------------------------------------------------------------------------
// Load: one edge request per cycle; input stalls from last_edge to end of run.
// Run: edge reads pass scan read, wait and check states; pass 1 reads all edges
//   once per node visited, pass 2 act_cnt times per node (once per candidate source).
// Emit: each result passes emit read, wait and emit states, plus output stalls.
// Reset: synchronous active-low; clears control state, edge count, visited
//   bits and node_count to 64. Memories are not cleared.
module strongly_connected_components #(
    parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_has_edge,
    input  logic [scc_pkg::NODE_W-1:0] i_from_node,
    input  logic [scc_pkg::NODE_W-1:0] i_to_node,
    input  logic                       i_last_edge,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [scc_pkg::NODE_W-1:0] o_node,
    output logic [scc_pkg::NODE_W-1:0] o_component_root,
    output logic                       o_end_of_component,
    output logic                       o_last,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [scc_pkg::NODE_W-1:0] i_cfg_data
);
    import scc_pkg::*;

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int NAW = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int FW  = 2 * NODE_W + ECW;

    typedef enum logic [3:0] {
        S_LOAD, S_P1_ROOT, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_CHK, S_POP_RD,
        S_POP_WAIT, S_P2_ROOT, S_P2_WAIT, S_EMIT_RD, S_EMIT_WAIT, S_EMIT
    } t_state;

    t_state             r_state;
    logic [NODE_W-1:0]  r_node_count;
    logic [ECW-1:0]     r_edges;
    logic [MAX_NODES:0] r_visited;
    logic               r_pass2;
    logic [NODE_W-1:0]  r_root;
    logic [NCW-1:0]     r_top;
    logic [NODE_W-1:0]  r_x;
    logic [ECW-1:0]     r_cur;
    logic [NODE_W-1:0]  r_src_sel;
    logic [NCW-1:0]     r_fin;
    logic [NCW-1:0]     r_fidx;
    logic [NCW-1:0]     r_mem_n;
    logic [NCW-1:0]     r_emit_i;
    logic [NODE_W-1:0]  r_least;
    logic [NODE_W-1:0]  r_o_node;
    logic [NODE_W-1:0]  r_o_root;
    logic               r_o_eoc;
    logic               r_o_last;
    logic               r_o_valid;

    logic [NODE_W-1:0] act_cnt;
    assign act_cnt = (r_node_count == '0) ? NODE_W'(1) :
                     (r_node_count > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) :
                     r_node_count;

    // edge memory
    logic              e_we;
    logic [EAW-1:0]    e_raddr;
    logic [NODE_W-1:0] e_src, e_dst;
    assign e_we = (r_state == S_LOAD) && i_valid && i_has_edge &&
                  (i_from_node != '0) && (i_from_node <= act_cnt) &&
                  (i_to_node != '0) && (i_to_node <= act_cnt) &&
                  (r_edges < ECW'(MAX_EDGES));
    assign e_raddr = r_cur[EAW-1:0];

    scc_edge_mem #(.MAX_EDGES(MAX_EDGES), .AW(EAW)) u_edge (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(r_edges[EAW-1:0]),
        .i_wsrc(i_from_node), .i_wdst(i_to_node), .i_raddr(e_raddr),
        .o_rsrc(e_src), .o_rdst(e_dst)
    );

    // stack memory
    logic           s_we;
    logic [NAW-1:0] s_waddr, s_raddr;
    logic [FW-1:0]  s_wdata, s_rdata;
    scc_node_mem #(.DEPTH(MAX_NODES), .AW(NAW), .DW(FW)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    // finish order memory
    logic              f_we;
    logic [NAW-1:0]    f_raddr;
    logic [NODE_W-1:0] f_rdata;
    scc_node_mem #(.DEPTH(MAX_NODES), .AW(NAW), .DW(NODE_W)) u_fin (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(r_fin[NAW-1:0]), .i_wdata(r_x),
        .i_raddr(f_raddr), .o_rdata(f_rdata)
    );

    // component member memory
    logic              m_we;
    logic [NODE_W-1:0] m_rdata;
    scc_node_mem #(.DEPTH(MAX_NODES), .AW(NAW), .DW(NODE_W)) u_mem (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(r_mem_n[NAW-1:0]), .i_wdata(r_x),
        .i_raddr(r_emit_i[NAW-1:0]), .o_rdata(m_rdata)
    );

    // scan match: first pass edge x->y; second pass edges by source order with target x
    logic              sc_match;
    logic [NODE_W-1:0] sc_y;
    always_comb begin
        if (!r_pass2) begin
            sc_match = (e_src == r_x);
            sc_y     = e_dst;
        end else begin
            sc_match = (e_src == r_src_sel) && (e_dst == r_x);
            sc_y     = e_src;
        end
    end

    logic at_end;
    assign at_end = (r_cur >= r_edges);
    logic push_ok;
    assign push_ok = r_top < NCW'(MAX_NODES);
    logic pop_done;
    assign pop_done = (r_pass2 ? r_mem_n : r_fin) < NCW'(MAX_NODES);
    logic push_hit;
    assign push_hit = sc_match && !r_visited[sc_y] && push_ok;

    // last flag: the component that leaves no unvisited node ends the run
    logic rest_visited;
    always_comb begin
        rest_visited = 1'b1;
        for (int i = 1; i <= MAX_NODES; i++) begin
            if (NODE_W'(i) <= act_cnt && !r_visited[i]) begin
                rest_visited = 1'b0;
            end
        end
    end

    logic comp_end;
    assign comp_end = (r_emit_i + NCW'(1) == r_mem_n);
    logic emit_fire;
    assign emit_fire = (r_state == S_EMIT) && (!r_o_valid || !i_stall);

    assign s_we    = (r_state == S_SCAN_CHK) && push_hit;
    assign s_waddr = NAW'(r_top - NCW'(1));
    assign s_wdata = {r_x, r_src_sel, ECW'(r_cur + ECW'(1))};
    assign s_raddr = NAW'(r_top - NCW'(2));
    assign f_we    = (r_state == S_POP_RD) && !r_pass2 && pop_done;
    assign m_we    = (r_state == S_POP_RD) && r_pass2 && pop_done;
    assign f_raddr = NAW'(r_fidx - NCW'(1));

    assign o_stall     = (r_state != S_LOAD);
    assign o_cfg_ready = (r_state == S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_node_count <= NODE_COUNT_RST;
            r_edges      <= '0;
            r_visited    <= '0;
            r_o_valid    <= 1'b0;
            r_pass2      <= 1'b0;
            r_top        <= '0;
            r_fin        <= '0;
            r_mem_n      <= '0;
        end else begin
            if (emit_fire) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_node_count <= i_cfg_data;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (i_valid) begin
                        if (e_we) begin
                            r_edges <= r_edges + ECW'(1);
                        end
                        if (i_last_edge) begin
                            r_visited <= '0;
                            r_pass2   <= 1'b0;
                            r_root    <= NODE_W'(1);
                            r_fin     <= '0;
                            r_state   <= S_P1_ROOT;
                        end
                    end
                end
                S_P1_ROOT: begin
                    if (r_root > act_cnt) begin
                        r_visited  <= '0;
                        r_pass2    <= 1'b1;
                        r_fidx     <= r_fin;
                        r_state    <= S_P2_ROOT;
                    end else if (r_visited[r_root]) begin
                        r_root <= r_root + NODE_W'(1);
                    end else begin
                        r_visited[r_root] <= 1'b1;
                        r_x       <= r_root;
                        r_cur     <= '0;
                        r_src_sel <= NODE_W'(1);
                        r_top     <= NCW'(1);
                        r_state   <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    if (r_pass2 && at_end && r_src_sel < act_cnt) begin
                        r_src_sel <= r_src_sel + NODE_W'(1);
                        r_cur     <= '0;
                    end else if (at_end) begin
                        r_state <= S_POP_RD;
                    end else begin
                        r_state <= S_SCAN_WAIT;
                    end
                end
                S_SCAN_WAIT: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    if (push_hit) begin
                        r_visited[sc_y] <= 1'b1;
                        // parent frame saved with cursor after this edge
                        r_x       <= sc_y;
                        r_cur     <= '0;
                        r_top     <= r_top + NCW'(1);
                        r_src_sel <= NODE_W'(1);
                    end else begin
                        r_cur <= r_cur + ECW'(1);
                    end
                    r_state <= S_SCAN_RD;
                end
                S_POP_RD: begin
                    if (f_we) begin
                        r_fin <= r_fin + NCW'(1);
                    end
                    if (m_we) begin
                        r_mem_n <= r_mem_n + NCW'(1);
                        if (r_mem_n == '0 || r_x < r_least) begin
                            r_least <= r_x;
                        end
                    end
                    r_top <= r_top - NCW'(1);
                    if (r_top == NCW'(1)) begin
                        if (r_pass2) begin
                            r_emit_i <= '0;
                            r_state  <= S_EMIT_RD;
                        end else begin
                            r_root  <= r_root + NODE_W'(1);
                            r_state <= S_P1_ROOT;
                        end
                    end else begin
                        r_state <= S_POP_WAIT;
                    end
                end
                S_POP_WAIT: begin
                    // restore parent node, source group and cursor
                    r_x       <= s_rdata[FW-1:NODE_W+ECW];
                    r_src_sel <= s_rdata[NODE_W+ECW-1:ECW];
                    r_cur     <= s_rdata[ECW-1:0];
                    r_state   <= S_SCAN_RD;
                end
                S_P2_ROOT: begin
                    if (r_fidx == '0) begin
                        r_state <= S_LOAD;
                        r_edges <= '0;
                    end else begin
                        r_state <= S_P2_WAIT;
                    end
                end
                S_P2_WAIT: begin
                    r_fidx <= r_fidx - NCW'(1);
                    if (r_visited[f_rdata]) begin
                        r_state <= S_P2_ROOT;
                    end else begin
                        r_visited[f_rdata] <= 1'b1;
                        r_x       <= f_rdata;
                        r_cur     <= '0;
                        r_src_sel <= NODE_W'(1);
                        r_top     <= NCW'(1);
                        r_mem_n   <= '0;
                        r_state   <= S_SCAN_RD;
                    end
                end
                S_EMIT_RD: begin
                    if (!r_o_valid || !i_stall) begin
                        r_state <= S_EMIT_WAIT;
                    end
                end
                S_EMIT_WAIT: r_state <= S_EMIT;
                S_EMIT: begin
                    if (emit_fire) begin
                        r_o_node   <= m_rdata;
                        r_o_root   <= r_least;
                        r_o_eoc    <= comp_end;
                        r_o_last   <= comp_end && rest_visited;
                        r_emit_i   <= r_emit_i + NCW'(1);
                        if (comp_end) begin
                            r_state <= S_P2_ROOT;
                        end else begin
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_valid            = r_o_valid;
    assign o_node             = r_o_node;
    assign o_component_root   = r_o_root;
    assign o_end_of_component = r_o_eoc;
    assign o_last             = r_o_last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_node))
        else $error("held result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_LOAD |-> o_stall)
        else $error("input accepted during run");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= NCW'(MAX_NODES))
        else $error("stack overflow");
endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives edge graphs into strongly_connected_components, predicts the
// component stream by a two-pass depth-first search and checks every result.
// ----------------------------------------------------------------------------
typedef struct packed {
    logic [6:0] node;
    logic [6:0] root;
    logic       eoc;
    logic       fin;
} t_scc_result;

class scc_scoreboard;
    int          nodes = 64;
    int          src[$];
    int          dst[$];
    int          bysrc[$];
    bit          seen[65];
    t_scc_result pending[$];
    int          mismatches = 0;

    function void walk(int start, bit tr, ref int sink[$]);
        int snode[64];
        int scur[64];
        int top;
        int x, c, y, k;
        bit found;
        seen[start] = 1;
        snode[0] = start;
        scur[0] = 0;
        top = 1;
        while (top > 0) begin
            x = snode[top-1];
            c = scur[top-1];
            found = 0;
            y = 0;
            while (c < src.size() && !found) begin
                if (!tr) begin
                    if (src[c] == x) begin
                        y = dst[c];
                        found = !seen[y];
                    end
                end else if (c < bysrc.size()) begin
                    k = bysrc[c];
                    if (dst[k] == x) begin
                        y = src[k];
                        found = !seen[y];
                    end
                end
                c++;
            end
            scur[top-1] = c;
            if (found && top < 64) begin
                seen[y] = 1;
                snode[top] = y;
                scur[top] = 0;
                top++;
            end else begin
                sink = {sink, x};
                top--;
            end
        end
    endfunction

    function void compute();
        int order[$];
        int members[$];
        int least, r;
        t_scc_result res;
        foreach (seen[i]) seen[i] = 0;
        for (int v = 1; v <= nodes; v++)
            if (!seen[v]) walk(v, 0, order);
        bysrc.delete();
        for (int v = 1; v <= nodes; v++)
            foreach (src[k]) if (src[k] == v) bysrc = {bysrc, k};
        foreach (seen[i]) seen[i] = 0;
        for (int v = order.size(); v > 0; v--) begin
            r = order[v-1];
            if (seen[r]) continue;
            members.delete();
            walk(r, 1, members);
            least = members[0];
            foreach (members[i]) if (members[i] < least) least = members[i];
            foreach (members[i]) begin
                res.node = 7'(members[i]);
                res.root = 7'(least);
                res.eoc  = (i == members.size() - 1);
                res.fin  = 0;
                pending = {pending, res};
            end
        end
        if (pending.size() > 0) pending[pending.size()-1].fin = 1;
        src.delete();
        dst.delete();
    endfunction

    function void note_request(bit has, int from, int to, bit lst);
        if (has && from >= 1 && from <= nodes && to >= 1 && to <= nodes &&
            src.size() < 256) begin
            src = {src, from};
            dst = {dst, to};
        end
        if (lst) compute();
    endfunction

    function void check_result(t_scc_result got);
        t_scc_result exp;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result node=%0d", got.node);
            return;
        end
        exp = pending.pop_front();
        if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch exp node=%0d root=%0d eoc=%0d last=%0d got %0d %0d %0d %0d",
                         exp.node, exp.root, exp.eoc, exp.fin,
                         got.node, got.root, got.eoc, got.fin);
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_valid = 0;
    logic       o_stall;
    logic       i_has_edge = 0;
    logic [6:0] i_from_node = 0;
    logic [6:0] i_to_node = 0;
    logic       i_last_edge = 0;
    logic       o_valid;
    logic       i_stall = 0;
    logic [6:0] o_node;
    logic [6:0] o_component_root;
    logic       o_end_of_component;
    logic       o_last;
    logic       i_cfg_valid = 0;
    logic       o_cfg_ready;
    logic [6:0] i_cfg_data = 0;

    scc_scoreboard sb = new();
    int  send_idle = 0;
    int  recv_idle = 0;
    int  hold_cycles = 0;
    bit  hold_arm = 0;
    bit  hold_used = 0;
    int  quiet = 0;
    int  sent = 0;
    bit  progress;

    strongly_connected_components u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_has_edge(i_has_edge), .i_from_node(i_from_node),
        .i_to_node(i_to_node), .i_last_edge(i_last_edge),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_node(o_node), .o_component_root(o_component_root),
        .o_end_of_component(o_end_of_component), .o_last(o_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1;
            hold_cycles <= hold_cycles - 1;
        end else if (hold_arm && !hold_used && o_valid) begin
            i_stall <= 1;
            hold_cycles <= 600;
            hold_used <= 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge i_clk) begin
        progress = 0;
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result('{o_node, o_component_root, o_end_of_component, o_last});
            progress = 1;
        end
        if (i_rst_n && ((i_valid && !o_stall) || (i_cfg_valid && o_cfg_ready))) progress = 1;
        if (progress) quiet = 0;
        else quiet++;
        if (quiet >= 20000000) begin
            $display("[strongly_connected_components] ERROR");
            $finish;
        end
    end

    task automatic send_request(bit has, int from, int to, bit lst);
        if ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid     <= 1;
        i_has_edge  <= has;
        i_from_node <= 7'(from);
        i_to_node   <= 7'(to);
        i_last_edge <= lst;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(has, from, to, lst);
        sent++;
    endtask

    task automatic write_count(int value);
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_data  <= 7'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.nodes = (value < 1) ? 1 : (value > 64) ? 64 : value;
    endtask

    task automatic send_graph(int edges, int span);
        int from, to;
        for (int i = 0; i < edges; i++) begin
            if ($urandom_range(19) == 0) begin
                send_request(0, $urandom_range(127), $urandom_range(127), 0);
            end
            if ($urandom_range(9) == 0) begin
                from = $urandom_range(127);
                to   = $urandom_range(127);
            end else begin
                from = $urandom_range(1, span);
                to   = $urandom_range(1, span);
            end
            send_request(1, from, to, 0);
        end
        send_request(1'($urandom_range(1)), $urandom_range(1, span),
                     $urandom_range(1, span), 1);
    endtask

    initial begin
        int n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_request(0, 0, 0, 0);
        send_request(0, 127, 127, 1);
        write_count(1);
        send_request(1, 1, 1, 0);
        send_request(1, 0, 1, 0);
        send_request(1, 1, 0, 1);
        write_count(5);
        send_request(1, 1, 2, 0);
        send_request(1, 2, 3, 0);
        send_request(1, 3, 1, 0);
        send_request(1, 5, 6, 0);
        send_request(1, 4, 5, 0);
        send_request(1, 5, 4, 1);
        write_count(0);
        send_request(1, 1, 1, 1);
        write_count(127);
        send_request(1, 64, 1, 0);
        send_request(1, 1, 64, 0);
        send_request(1, 65, 2, 0);
        send_request(1, 3, 127, 0);
        send_request(1, 63, 64, 1);
        write_count(64);
        send_request(0, 0, 0, 1);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 18 : (phase == 1) ? 61 : 0;
            recv_idle = (phase == 0) ? 61 : (phase == 1) ? 18 : 0;
            if (phase == 1) begin
                write_count(64);
                hold_arm = 1;
                send_graph(40, 64);
                send_graph(6, 64);
            end
            if (phase == 2) begin
                write_count(64);
                for (int i = 0; i < 260; i++)
                    send_request(1, $urandom_range(1, 64), $urandom_range(1, 64), 0);
                send_request(0, 0, 0, 1);
            end
            while (phase < 2 && sent < 50 * (phase + 1)) begin
                n = ($urandom_range(7) == 0) ? 64 : $urandom_range(1, 12);
                write_count(n);
                send_graph($urandom_range(0, 15), n);
            end
        end

        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("[strongly_connected_components] OK");
        else
            $display("[strongly_connected_components] ERROR");
        $finish;
    end
endmodule
